@@ rtl/per_channel_mean_rms_accumulator_defines.svh @@
// Assertion macros used by the accumulator controller.
`ifndef PER_CHANNEL_MEAN_RMS_ACCUMULATOR_DEFINES_SVH
`define PER_CHANNEL_MEAN_RMS_ACCUMULATOR_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define PCMA_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define PCMA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define PCMA_ASSERT_SAME(lbl, ante, cons, msg)
`define PCMA_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

@@ rtl/pcma_pkg.sv @@
// Types and constants shared by the accumulator modules.
`default_nettype none
package pcma_pkg;
  localparam int CNT_W     = 32;
  localparam int OUT_W     = 16;
  localparam int MEAN_FRAC = 6;
  localparam int MSQ_FRAC  = 12;
  localparam int MSQ_W     = 32;
  localparam int IN_SMP_W  = 10;
  localparam int BOARD_W   = 5;
  localparam int CHAN_W    = 8;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_RD, ST_DEC, ST_DIVM, ST_DIVQ, ST_SQRT, ST_OUT
  } state_t;

  typedef struct packed {
    logic clr_we;
    logic rd_en;
    logic latch_ent;
    logic acc_we;
    logic div_start;
    logic div_sel;
    logic sqrt_start;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic is_read;
    logic stat_zero;
    logic div_done;
    logic sqrt_done;
    logic out_busy;
  } sts_t;
endpackage
`default_nettype wire

@@ rtl/pcma_ram.sv @@
// Generic simple dual-port RAM with registered read.
`default_nettype none
module pcma_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

@@ rtl/pcma_ctrl.sv @@
// Controller state machine sequencing clear, accumulate and read items.
`default_nettype none
`include "per_channel_mean_rms_accumulator_defines.svh"
module pcma_ctrl
  import pcma_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_tvalid,
  output logic      in_tready,
  input  wire sts_t sts,
  output cmd_t      cmd
);
  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_we = 1'b1;
        if (sts.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.rd_en = 1'b1;
          state_nxt = ST_RD;
        end
      end
      ST_RD: begin
        cmd.latch_ent = 1'b1;
        state_nxt = ST_DEC;
      end
      ST_DEC: begin
        if (!sts.is_read) begin
          cmd.acc_we = 1'b1;
          state_nxt = ST_IDLE;
        end else if (sts.stat_zero) begin
          state_nxt = ST_OUT;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt = ST_DIVM;
        end
      end
      ST_DIVM: begin
        if (sts.div_done) begin
          cmd.div_start = 1'b1;
          cmd.div_sel = 1'b1;
          state_nxt = ST_DIVQ;
        end
      end
      ST_DIVQ: begin
        if (sts.div_done) begin
          cmd.sqrt_start = 1'b1;
          state_nxt = ST_SQRT;
        end
      end
      ST_SQRT: begin
        if (sts.sqrt_done) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  `PCMA_ASSERT_NEXT(a_accept_leaves_idle, in_tvalid && in_tready, state_r == ST_RD, "accepted item did not start a lookup")
  `PCMA_ASSERT_SAME(a_write_only_accum, cmd.acc_we, !sts.is_read, "store written for a read item")
  `PCMA_ASSERT_SAME(a_no_div_in_clear, state_r == ST_CLEAR, !cmd.div_start && !in_tready, "work started during clear")
endmodule
`default_nettype wire

@@ rtl/pcma_dp.sv @@
// Datapath: channel store, serial divider, serial square root and output register.
`default_nettype none
module pcma_dp
  import pcma_pkg::*;
#(
  parameter int NUM_BOARDS = 32,
  parameter int CHANNELS_PER_BOARD = 256,
  parameter int SAMPLE_BITS = 10
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_command,
  input  wire logic [BOARD_W-1:0]  in_board,
  input  wire logic [CHAN_W-1:0]   in_chan,
  input  wire logic [IN_SMP_W-1:0] in_sample,
  input  wire cmd_t                cmd,
  output sts_t                     sts,
  output logic                     out_tvalid,
  input  wire logic                out_tready,
  output logic [63:0]              out_tdata,
  output logic [0:0]               out_tuser
);
  localparam int NUM_CH = NUM_BOARDS * CHANNELS_PER_BOARD;
  localparam int AW     = (NUM_CH > 1) ? $clog2(NUM_CH) : 1;
  localparam int SUM_W  = SAMPLE_BITS + CNT_W;
  localparam int SQ_W   = 2 * SAMPLE_BITS + CNT_W;
  localparam int ENT_W  = CNT_W + SQ_W + SUM_W;
  localparam int DIV_W  = SQ_W + MSQ_FRAC;
  localparam int STEP_W = $clog2(DIV_W);

  logic [AW-1:0]         clr_cnt_r;
  logic [AW-1:0]         idx_r;
  logic                  valid_r;
  logic                  read_r;
  logic [IN_SMP_W-1:0]   smp_r;
  logic [SUM_W-1:0]      sum_r;
  logic [SQ_W-1:0]       sq_r;
  logic [CNT_W-1:0]      cnt_r;
  logic [ENT_W-1:0]      rdata;
  logic [ENT_W-1:0]      wdata;
  logic [AW-1:0]         waddr;
  logic                  we;
  logic [31:0]           idx_full;
  logic                  in_ok;
  logic [IN_SMP_W-1:0]   smp_mask;
  logic [2*IN_SMP_W-1:0] smp_sq;

  assign smp_mask = IN_SMP_W'((33'd1 << SAMPLE_BITS) - 33'd1);
  assign idx_full = 32'(in_board) * 32'(CHANNELS_PER_BOARD) + 32'(in_chan);
  assign in_ok = (32'(in_board) < 32'(NUM_BOARDS)) && (32'(in_chan) < 32'(CHANNELS_PER_BOARD));
  assign smp_sq = smp_r * smp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_we) begin
      clr_cnt_r <= clr_cnt_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      idx_r   <= in_ok ? idx_full[AW-1:0] : '0;
      valid_r <= in_ok;
      read_r  <= in_command;
      smp_r   <= in_sample & smp_mask;
    end
    if (cmd.latch_ent) begin
      sum_r <= rdata[SUM_W-1:0];
      sq_r  <= rdata[SUM_W +: SQ_W];
      cnt_r <= rdata[SUM_W+SQ_W +: CNT_W];
    end
  end

  always_comb begin
    if (cmd.clr_we) begin
      we    = 1'b1;
      waddr = clr_cnt_r;
      wdata = '0;
    end else begin
      we    = cmd.acc_we && valid_r && (cnt_r != '1);
      waddr = idx_r;
      wdata = {cnt_r + CNT_W'(1), sq_r + SQ_W'(smp_sq), sum_r + SUM_W'(smp_r)};
    end
  end

  pcma_ram #(.WIDTH(ENT_W), .DEPTH(NUM_CH)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (cmd.rd_en),
    .raddr (in_ok ? idx_full[AW-1:0] : AW'(0)),
    .rdata (rdata)
  );

  logic [DIV_W-1:0]  quo_r;
  logic [CNT_W:0]    rem_r;
  logic [CNT_W-1:0]  den_r;
  logic [STEP_W-1:0] step_r;
  logic              div_busy_r, div_done_r, div_sel_r;
  logic [CNT_W:0]    rem_sh;
  logic              div_ge;

  assign rem_sh = {rem_r[CNT_W-1:0], quo_r[DIV_W-1]};
  assign div_ge = rem_sh >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_busy_r <= 1'b0;
      div_done_r <= 1'b0;
    end else begin
      div_done_r <= 1'b0;
      if (cmd.div_start) begin
        div_busy_r <= 1'b1;
      end else if (div_busy_r && step_r == STEP_W'(DIV_W - 1)) begin
        div_busy_r <= 1'b0;
        div_done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      quo_r     <= cmd.div_sel ? {sq_r, {MSQ_FRAC{1'b0}}}
                               : DIV_W'({sum_r, {MEAN_FRAC{1'b0}}});
      rem_r     <= '0;
      den_r     <= cnt_r;
      step_r    <= '0;
      div_sel_r <= cmd.div_sel;
    end else if (div_busy_r) begin
      quo_r  <= {quo_r[DIV_W-2:0], div_ge};
      rem_r  <= div_ge ? rem_sh - {1'b0, den_r} : rem_sh;
      step_r <= step_r + STEP_W'(1);
    end
  end

  logic [OUT_W-1:0] mean_r;
  logic [MSQ_W-1:0] msq_sat;

  assign msq_sat = (|quo_r[DIV_W-1:MSQ_W]) ? '1 : quo_r[MSQ_W-1:0];

  always_ff @(posedge clk) begin
    if (div_done_r && !div_sel_r) begin
      mean_r <= (|quo_r[DIV_W-1:OUT_W]) ? '1 : quo_r[OUT_W-1:0];
    end
  end

  logic [MSQ_W-1:0] sv_r, sres_r, sbit_r;
  logic             sq_busy_r, sq_done_r;
  logic [MSQ_W-1:0] strial;
  logic             sq_ge;

  assign strial = sres_r + sbit_r;
  assign sq_ge  = sv_r >= strial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_busy_r <= 1'b0;
      sq_done_r <= 1'b0;
    end else begin
      sq_done_r <= 1'b0;
      if (cmd.sqrt_start) begin
        sq_busy_r <= 1'b1;
      end else if (sq_busy_r && sbit_r[0]) begin
        sq_busy_r <= 1'b0;
        sq_done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sqrt_start) begin
      sv_r   <= msq_sat;
      sres_r <= '0;
      sbit_r <= MSQ_W'(1) << (MSQ_W - 2);
    end else if (sq_busy_r) begin
      sv_r   <= sq_ge ? sv_r - strial : sv_r;
      sres_r <= sq_ge ? (sres_r >> 1) + sbit_r : sres_r >> 1;
      sbit_r <= sbit_r >> 2;
    end
  end

  logic        out_valid_r;
  logic [63:0] out_data_r;
  logic        out_full_r;
  logic        zero;

  assign zero = !valid_r || (cnt_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r <= zero ? '0 : {cnt_r, sres_r[OUT_W-1:0], mean_r};
      out_full_r <= !zero && (cnt_r == '1);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_full_r;

  always_comb begin
    sts.clr_last  = clr_cnt_r == AW'(NUM_CH - 1);
    sts.is_read   = read_r;
    sts.stat_zero = zero;
    sts.div_done  = div_done_r;
    sts.sqrt_done = sq_done_r;
    sts.out_busy  = out_valid_r && !out_tready;
  end
endmodule
`default_nettype wire

@@ rtl/per_channel_mean_rms_accumulator.sv @@
// Accumulate item: after acceptance the controller passes through ST_RD and ST_DEC
// before the next item can be taken. Read item: the bit-serial divider runs twice, for the
// mean and the mean square, then the 16-step square root; an empty channel skips them.
// Only one item is in work at a time; a result waits in the output register.
// After reset the store is cleared, one entry per cycle, all
// NUM_BOARDS * CHANNELS_PER_BOARD entries (8192 at the defaults), before items are taken.
`default_nettype none
module per_channel_mean_rms_accumulator
  import pcma_pkg::*;
#(
  parameter int NUM_BOARDS = 32,
  parameter int CHANNELS_PER_BOARD = 256,
  parameter int SAMPLE_BITS = 10
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,  // board_number, channel_number, sample_value
  input  wire logic [0:0]  in_tuser,  // command
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [63:0]      out_tdata, // mean_q6, rms_q6, sample_count
  output logic [0:0]       out_tuser  // count_full
);
  cmd_t cmd;
  sts_t sts;

  pcma_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  pcma_dp #(
    .NUM_BOARDS         (NUM_BOARDS),
    .CHANNELS_PER_BOARD (CHANNELS_PER_BOARD),
    .SAMPLE_BITS        (SAMPLE_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_command (in_tuser[0]),
    .in_board   (in_tdata[4:0]),
    .in_chan    (in_tdata[12:5]),
    .in_sample  (in_tdata[22:13]),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );
endmodule
`default_nettype wire

@@ tb/tb_per_channel_mean_rms_accumulator.sv @@
// Self-checking testbench for the per-channel mean and RMS accumulator.
`timescale 1ns / 100ps
`default_nettype none
module tb_per_channel_mean_rms_accumulator;
  import pcma_pkg::*;

  localparam int NUM_CH     = 32 * 256;
  localparam int WD_LIMIT   = 40000;
  localparam int HOLD_LEN   = 400;
  localparam bit CMD_ACCUM  = 1'b0;
  localparam bit CMD_READ   = 1'b1;

  typedef struct packed {
    logic [15:0] mean_q6;
    logic [15:0] rms_q6;
    logic [31:0] sample_count;
    logic        count_full;
  } chan_stats_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;
  logic [0:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;
  logic [0:0]  out_tuser;

  longint unsigned acc_sum [NUM_CH];
  longint unsigned acc_sqsum [NUM_CH];
  longint unsigned acc_cnt [NUM_CH];
  chan_stats_t     pending_stats[$];
  int              mismatches;
  int              burst_left;
  int              hold_req;
  int              hold_seen;
  int              hold_cnt;
  int              stall_mode;
  int              cyc;
  int              idle_cycles;
  int              hot_ch [6];

  per_channel_mean_rms_accumulator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned step;
    res  = 0;
    step = 64'h4000_0000_0000_0000;
    while (step > v) step >>= 2;
    while (step != 0) begin
      if (v >= res + step) begin
        v   -= res + step;
        res  = (res >> 1) + step;
      end else begin
        res >>= 1;
      end
      step >>= 2;
    end
    return res;
  endfunction

  function automatic longint unsigned frac_quotient(longint unsigned num, longint unsigned den,
                                                    int fbits, longint unsigned lim);
    longint unsigned q;
    longint unsigned r;
    longint unsigned v;
    q = num / den;
    r = num % den;
    if (q > (lim >> fbits)) return lim;
    v = (q << fbits) + ((r << fbits) / den);
    return (v > lim) ? lim : v;
  endfunction

  function automatic chan_stats_t stats_of(int idx);
    chan_stats_t     s;
    longint unsigned n;
    longint unsigned msq;
    longint unsigned root;
    s = '0;
    n = acc_cnt[idx];
    if (n != 0) begin
      msq            = frac_quotient(acc_sqsum[idx], n, MSQ_FRAC, 64'hFFFF_FFFF);
      root           = floor_sqrt(msq);
      s.mean_q6      = 16'(frac_quotient(acc_sum[idx], n, MEAN_FRAC, 64'hFFFF));
      s.rms_q6       = (root > 64'hFFFF) ? 16'hFFFF : root[15:0];
      s.sample_count = n[31:0];
      s.count_full   = (n == 64'hFFFF_FFFF);
    end
    return s;
  endfunction

  task automatic send_item(bit cmd, int board, int chan, int sample);
    int gap;
    int idx;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
    end
    burst_left--;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {1'b0, sample[9:0], chan[7:0], board[4:0]};
    do @(posedge clk); while (!in_tready);
    idx = board * 256 + chan;
    if (cmd == CMD_READ) begin
      pending_stats.push_back(stats_of(idx));
    end else if (acc_cnt[idx] != 64'hFFFF_FFFF) begin
      acc_sum[idx]   += sample;
      acc_sqsum[idx] += sample * sample;
      acc_cnt[idx]++;
    end
  endtask

  task automatic stop_sending();
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (pending_stats.size() != 0) @(posedge clk);
  endtask

  task automatic test_empty_channels();
    send_item(CMD_READ, 0, 0, 0);
    send_item(CMD_READ, 31, 255, 1023);
    send_item(CMD_READ, 21, 170, 0);
  endtask

  task automatic test_extreme_samples();
    repeat (3) send_item(CMD_ACCUM, 31, 255, 1023);
    send_item(CMD_READ, 31, 255, 0);
    send_item(CMD_ACCUM, 0, 0, 0);
    send_item(CMD_READ, 0, 0, 0);
    send_item(CMD_ACCUM, 10, 85, 10'h2AA);
    send_item(CMD_ACCUM, 10, 85, 10'h155);
    send_item(CMD_ACCUM, 10, 85, 1);
    send_item(CMD_READ, 10, 85, 0);
    send_item(CMD_ACCUM, 21, 170, 1023);
    send_item(CMD_ACCUM, 21, 170, 0);
    send_item(CMD_READ, 21, 170, 0);
  endtask

  task automatic test_output_backpressure();
    hold_req++;
    repeat (12) begin
      send_item(CMD_ACCUM, 3, 7, $urandom_range(0, 1023));
      send_item(CMD_READ, 3, 7, 0);
    end
  endtask

  task automatic test_drain_pause();
    stop_sending();
    wait_drained();
    send_item(CMD_READ, 3, 7, 0);
    send_item(CMD_ACCUM, 3, 7, 512);
    send_item(CMD_READ, 3, 7, 0);
  endtask

  task automatic test_random_traffic(int n_items);
    int pick;
    int idx;
    int sample;
    for (int i = 0; i < n_items; i++) begin
      pick   = $urandom_range(0, 99);
      idx    = (pick < 80 || (pick >= 85 && pick < 97)) ? hot_ch[$urandom_range(0, 5)]
                                                         : $urandom_range(0, NUM_CH - 1);
      case ($urandom_range(0, 5))
        0:       sample = 1023;
        1:       sample = $urandom_range(0, 3);
        default: sample = $urandom_range(0, 1023);
      endcase
      send_item((pick < 85) ? CMD_ACCUM : CMD_READ, idx / 256, idx % 256, sample);
      if (i % 300 == 299) begin
        stop_sending();
        repeat ($urandom_range(1, 40)) @(posedge clk);
      end
    end
  endtask

  always @(posedge clk) begin
    chan_stats_t got;
    chan_stats_t want;
    cyc <= cyc + 1;
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= WD_LIMIT) begin
      $display("per_channel_mean_rms_accumulator: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tdata[15:0], out_tdata[31:16], out_tdata[63:32], out_tuser[0]};
      if (pending_stats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item: %p", got);
      end else begin
        want = pending_stats.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("result mismatch: expected %p, got %p", want, got);
        end
      end
    end
    if (cyc % 64 == 0) stall_mode <= $urandom_range(0, 2);
    if (hold_req != hold_seen) begin
      hold_seen  <= hold_req;
      hold_cnt   <= HOLD_LEN;
      out_tready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt   <= hold_cnt - 1;
      out_tready <= 1'b0;
    end else begin
      case (stall_mode)
        0:       out_tready <= 1'b1;
        1:       out_tready <= $urandom_range(0, 1);
        default: out_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  initial begin
    mismatches  = 0;
    burst_left  = 0;
    hold_req    = 0;
    hold_seen   = 0;
    hold_cnt    = 0;
    stall_mode  = 0;
    cyc         = 0;
    idle_cycles = 0;
    for (int i = 0; i < NUM_CH; i++) begin
      acc_sum[i]   = 0;
      acc_sqsum[i] = 0;
      acc_cnt[i]   = 0;
    end
    for (int i = 0; i < 6; i++) hot_ch[i] = $urandom_range(0, NUM_CH - 1);
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tuser   <= '0;
    out_tready <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_channels();
    test_extreme_samples();
    test_output_backpressure();
    test_drain_pause();
    test_random_traffic(1100);
    stop_sending();
    wait_drained();
    repeat (300) @(posedge clk);
    if (mismatches == 0 && pending_stats.size() == 0) begin
      $display("per_channel_mean_rms_accumulator: match");
    end else begin
      $display("per_channel_mean_rms_accumulator: mismatch");
    end
    $finish;
  end
endmodule
`default_nettype wire
